// ===== rtl/bavg_pkg.sv =====
package bavg_pkg;

    localparam int MAX_WINDOW = 128;

    localparam int SAMPLE_W = 12;
    localparam int WLEN_W   = 8;
    localparam int MV_W     = 13;
    localparam int PCT_W    = 7;
    localparam int LED_W    = 4;

    localparam int POS_W = $clog2(MAX_WINDOW);
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int EXT_W = (WLEN_W > WIN_W) ? WLEN_W : WIN_W;
    localparam int SUM_W = SAMPLE_W + POS_W;

    localparam int PCT_NUM_W = 20;
    localparam int DIVD_W    = (SUM_W > PCT_NUM_W) ? SUM_W : PCT_NUM_W;
    localparam int DEN_W     = MV_W;
    localparam int DIV_CNT_W = $clog2(DIVD_W);

    localparam int SCALE_NUM   = 83;
    localparam int SCALE_DEN   = 50;
    localparam int SCALED_W    = SAMPLE_W + 7;
    localparam int RECIP       = 5243;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 18;
    localparam int PROD_W      = SCALED_W + RECIP_W;

    localparam int PCT_FULL   = 100;
    localparam int LED_MUL    = 171;
    localparam int LED_SHIFT  = 11;
    localparam int LED_PROD_W = 15;

    localparam int S_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((MV_W + PCT_W + LED_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY  = 2'd2;

    localparam logic [WLEN_W-1:0] WINDOW_RESET = 8'd16;
    localparam logic [MV_W-1:0]   FULL_RESET   = 13'd4200;
    localparam logic [MV_W-1:0]   EMPTY_RESET  = 13'd3300;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DEN_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/bavg_ram.sv =====
module bavg_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 128,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bavg_div.sv =====
module bavg_div import bavg_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DIVD_W-1:0]    quo_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] rem_next;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        trial    = {rem_reg, quo_reg[DIVD_W-1]};
        fits     = (trial >= {1'b0, den_reg});
        diff     = trial - {1'b0, den_reg};
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIVD_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            den_reg <= req.divisor;
            quo_reg <= req.dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/battery_level_averager.sv =====
// Channel  Direction  Transfer moves
// s_       in         one ADC sample in millivolts
// m_       out        battery millivolts, charge percent and LED level
// cfg_     in         one register write (window, full level, empty level)
//
// An item is averaged by division, scaled to millivolts and given a charge,
// with a second division unless the charge is decided directly; the shared
// serial divider works one quotient bit per cycle. The sample ring is a
// 128-entry memory read and written back once per item. Reset clears the
// fill count, so no clearing pass is needed. A finished result waits in the
// output register while the next sample is taken; the block holds only if full.
module battery_level_averager import bavg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // sample_mv
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // battery_mv, charge_percent, led_level
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_UPDATE  = 4'd1;
    localparam logic [3:0] ST_AVG     = 4'd2;
    localparam logic [3:0] ST_MUL     = 4'd3;
    localparam logic [3:0] ST_RECIP   = 4'd4;
    localparam logic [3:0] ST_FIX     = 4'd5;
    localparam logic [3:0] ST_PCT     = 4'd6;
    localparam logic [3:0] ST_PCT_DIV = 4'd7;
    localparam logic [3:0] ST_OUT     = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [WLEN_W-1:0]   window_reg;
    logic [MV_W-1:0]     full_mv_reg;
    logic [MV_W-1:0]     empty_mv_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                ring_full_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [MV_W-1:0]     mv_reg;
    logic [PCT_W-1:0]    pct_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic                in_xfer;
    logic                cfg_xfer;
    logic [WIN_W-1:0]    win_eff;
    logic [POS_W-1:0]    pos_eff;
    logic [WIN_W-1:0]    pos_inc;
    logic [SAMPLE_W-1:0] old_sample;
    logic [SUM_W-1:0]    sum_new;
    logic [WIN_W-1:0]    avg_den;
    logic [PROD_W-RECIP_SHIFT-1:0] q_est;
    logic [SCALED_W-1:0] q_back;
    logic [MV_W-1:0]     mv_fixed;
    logic [MV_W-1:0]     mv_span;
    logic [MV_W-1:0]     mv_above;
    logic                limits_inverted;
    logic                below_empty;
    logic [PCT_W-1:0]    pct_direct;
    logic [PCT_W-1:0]    pct_div;
    logic [LED_PROD_W-1:0] led_prod;
    logic                out_free;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        if (window_reg == '0) begin
            win_eff = WIN_W'(1);
        end else if (EXT_W'(window_reg) > EXT_W'(MAX_WINDOW)) begin
            win_eff = WIN_W'(MAX_WINDOW);
        end else begin
            win_eff = WIN_W'(EXT_W'(window_reg));
        end
        pos_eff = (WIN_W'(pos_reg) >= win_eff) ? '0 : pos_reg;
        pos_inc = WIN_W'(pos_reg) + 1'b1;
        if (ring_full_reg) begin
            sum_new = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
            avg_den = win_eff;
        end else begin
            sum_new = sum_reg + SUM_W'(sample_reg);
            avg_den = pos_inc;
        end
    end

    // Read of the old entry is issued with the transfer; write-back follows in the
    // next cycle, and only one item is in flight, so accesses never overlap.
    bavg_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk  (aclk),
        .we    (state_reg == ST_UPDATE),
        .waddr (pos_reg),
        .wdata (sample_reg),
        .re    (in_xfer),
        .raddr (pos_eff),
        .rdata (old_sample)
    );

    // The estimate of x / 50 is exact or one too high.
    always_comb begin
        q_est    = prod_reg[PROD_W-1:RECIP_SHIFT];
        q_back   = SCALED_W'(q_est) * SCALED_W'(SCALE_DEN);
        mv_fixed = (scaled_reg < q_back) ? MV_W'(q_est - 1'b1) : MV_W'(q_est);
    end

    always_comb begin
        limits_inverted = (full_mv_reg <= empty_mv_reg);
        below_empty     = (mv_reg <= empty_mv_reg);
        mv_span         = full_mv_reg - empty_mv_reg;
        mv_above        = mv_reg - empty_mv_reg;
        if (limits_inverted && (mv_reg >= full_mv_reg)) begin
            pct_direct = PCT_W'(PCT_FULL);
        end else begin
            pct_direct = '0;
        end
        if (div_rsp.quotient > DIVD_W'(PCT_FULL)) begin
            pct_div = PCT_W'(PCT_FULL);
        end else begin
            pct_div = div_rsp.quotient[PCT_W-1:0];
        end
        led_prod = LED_PROD_W'(pct_reg) * LED_PROD_W'(LED_MUL);
    end

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = DIVD_W'(sum_new);
        div_req.divisor  = DEN_W'(avg_den);
        case (state_reg)
            ST_UPDATE: begin
                div_req.start = 1'b1;
            end
            ST_PCT: begin
                div_req.start    = !limits_inverted && !below_empty;
                div_req.dividend = DIVD_W'(PCT_NUM_W'(mv_above) * PCT_NUM_W'(PCT_FULL));
                div_req.divisor  = mv_span;
            end
            default: begin
            end
        endcase
    end

    bavg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (in_xfer) state_next = ST_UPDATE;
            ST_UPDATE:  state_next = ST_AVG;
            ST_AVG:     if (div_rsp.done) state_next = ST_MUL;
            ST_MUL:     state_next = ST_RECIP;
            ST_RECIP:   state_next = ST_FIX;
            ST_FIX:     state_next = ST_PCT;
            ST_PCT:     state_next = div_req.start ? ST_PCT_DIV : ST_OUT;
            ST_PCT_DIV: if (div_rsp.done) state_next = ST_OUT;
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            window_reg    <= WINDOW_RESET;
            full_mv_reg   <= FULL_RESET;
            empty_mv_reg  <= EMPTY_RESET;
            sum_reg       <= '0;
            pos_reg       <= '0;
            ring_full_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_xfer) begin
                pos_reg <= pos_eff;
            end
            if (state_reg == ST_UPDATE) begin
                sum_reg <= sum_new;
                if (pos_inc >= win_eff) begin
                    pos_reg       <= '0;
                    ring_full_reg <= 1'b1;
                end else begin
                    pos_reg <= pos_inc[POS_W-1:0];
                end
            end
            if ((state_reg == ST_OUT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_xfer) begin
                case (cfg_index)
                    REG_WINDOW: begin
                        window_reg    <= cfg_data[WLEN_W-1:0];
                        sum_reg       <= '0;
                        pos_reg       <= '0;
                        ring_full_reg <= 1'b0;
                    end
                    REG_FULL:  full_mv_reg  <= cfg_data[MV_W-1:0];
                    REG_EMPTY: empty_mv_reg <= cfg_data[MV_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
        if ((state_reg == ST_AVG) && div_rsp.done) begin
            avg_reg <= div_rsp.quotient[SAMPLE_W-1:0];
        end
        if (state_reg == ST_MUL) begin
            scaled_reg <= SCALED_W'(avg_reg) * SCALED_W'(SCALE_NUM);
        end
        if (state_reg == ST_RECIP) begin
            prod_reg <= PROD_W'(scaled_reg) * PROD_W'(RECIP);
        end
        if (state_reg == ST_FIX) begin
            mv_reg <= mv_fixed;
        end
        if ((state_reg == ST_PCT) && !div_req.start) begin
            pct_reg <= pct_direct;
        end
        if ((state_reg == ST_PCT_DIV) && div_rsp.done) begin
            pct_reg <= pct_div;
        end
        if ((state_reg == ST_OUT) && out_free) begin
            m_tdata_reg <= M_TDATA_W'({led_prod[LED_SHIFT +: LED_W], pct_reg, mv_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready)
        else $error("A second sample could be taken while one is in progress.");

    a_pos_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (WIN_W'(pos_reg) < win_eff))
        else $error("The ring position lies outside the window.");

    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> ((state_reg == ST_AVG) || (state_reg == ST_PCT_DIV)))
        else $error("The divider finished while no quotient was awaited.");

    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ((m_tdata[MV_W +: PCT_W] <= PCT_W'(PCT_FULL))
            && (m_tdata[MV_W + PCT_W +: LED_W] <= LED_W'(PCT_FULL / 12))))
        else $error("The charge or LED level is out of range.");
`endif

endmodule
